[hdl/pts_pkg.sv]
// Package for the priority thread scheduler: sizes, codes and shared types.
// Used by the thread table, the picker and the top level. No dependencies.
package pts_pkg;

  // Number of scheduled threads; index THREADS is the idle thread.
  localparam int THREADS = 8;
  localparam int TID_W   = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int IDX_W   = $clog2(THREADS + 1);
  localparam int CMP_W   = (IDX_W > 3) ? IDX_W : 3;
  localparam int VEC_W   = (THREADS > 8) ? THREADS : 8;
  localparam int CTR_W   = TID_W + 1;

  // Field widths fixed by the interface.
  localparam int ACT_W   = 3;
  localparam int THR_W   = 3;
  localparam int TIME_W  = 32;
  localparam int RUN_W   = 4;
  localparam int MASK_W  = 8;
  localparam int PRIO_W  = 8;
  localparam int CFG_W   = 64;

  typedef enum logic [ACT_W-1:0] {
    ACT_START   = 3'd0,
    ACT_TICK    = 3'd1,
    ACT_SUSPEND = 3'd2,
    ACT_BLOCK   = 3'd3,
    ACT_RESUME  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_READY = 2'd1,
    ST_SUSP  = 2'd2,
    ST_BLOCK = 2'd3
  } status_e;

  typedef enum logic {
    REG_THREAD_ENABLE = 1'b0,
    REG_PRIORITIES    = 1'b1
  } reg_e;

  // One entry of the thread table.
  typedef struct packed {
    status_e            status;
    logic [TIME_W-1:0]  wake;
  } entry_t;

  // Write request into the thread table.
  typedef struct packed {
    logic              en;
    logic [TID_W-1:0]  addr;
    entry_t            data;
  } tbl_wr_t;

  // One updated entry handed to the picker.
  typedef struct packed {
    logic               clear;
    logic               valid;
    logic [TID_W-1:0]   idx;
    logic               ready;
    logic [PRIO_W-1:0]  prio;
  } pick_upd_t;

  // Priority of thread i; threads 8 and above have priority zero.
  function automatic logic [PRIO_W-1:0] prio_of(input logic [CFG_W-1:0] p,
                                                input logic [TID_W-1:0] i);
    logic [PRIO_W-1:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (k < THREADS && i == TID_W'(k)) begin
        r = p[PRIO_W*k +: PRIO_W];
      end
    end
    return r;
  endfunction

  // Enable bit of thread i; threads 8 and above are never created.
  function automatic logic enabled_of(input logic [MASK_W-1:0] e,
                                      input logic [TID_W-1:0] i);
    logic r;
    r = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (k < THREADS && i == TID_W'(k)) begin
        r = e[k];
      end
    end
    return r;
  endfunction

endpackage

[hdl/pts_if.sv]
// Channel interfaces of the priority thread scheduler: request and result words.
// Depends on nothing; widths match the fields in pts_pkg.
interface pts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  thread_index;
  logic [31:0] delay;

  modport source (output valid, output action, output thread_index, output delay,
                  input ready);
  modport sink (input valid, input action, input thread_index, input delay,
                output ready);
endinterface

interface pts_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  running_thread;
  logic [31:0] tick_count;
  logic [7:0]  ready_mask;

  modport source (output valid, output running_thread, output tick_count,
                  output ready_mask, input ready);
  modport sink (input valid, input running_thread, input tick_count,
                input ready_mask, output ready);
endinterface

[hdl/priority_thread_scheduler.sv]
// Priority thread scheduler: top level with sequencer, registers and result stage.
// Depends on pts_pkg, pts_if, pts_table and pts_picker.
//
// Usage: each request word on in_i carries an action (start, tick, suspend,
// block, resume), a thread index and a delay. Every request gives exactly one
// result word on out_o: the running thread, the tick counter and the set of
// ready threads that are not running, all as they stand after the action.
// thread_enable and priorities are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i while no request is in flight.
// Timing: a request sweeps the thread table once, one entry read and one
// written back per cycle. Its result word is registered in S_DONE once the
// sweep is over, and the next request can be accepted only when the sequencer
// is back in S_IDLE, so one request is swept at a time; the single table port
// pair sets this pace.
// The result register lets a new request be accepted while the last result
// still waits; if the receiver stalls, the next request finishes its sweep and
// holds until the result register is free.
// Reset clears the valid bits of the table (all threads not created, wake
// times zero), the tick counter, the registers, and sets the idle thread.
module priority_thread_scheduler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pts_in_if.sink                    in_i,
  pts_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [pts_pkg::CFG_W-1:0] cfg_wdata_i
);
  import pts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [CTR_W-1:0]     ctr_q;
  logic                 pend_q;
  logic [TID_W-1:0]     pidx_q;
  action_e              act_q;
  logic [THR_W-1:0]     idx_q;
  logic [TIME_W-1:0]    delay_q;
  logic [TIME_W-1:0]    cnt_q;
  logic [IDX_W-1:0]     run_q;
  logic [MASK_W-1:0]    en_q;
  logic [CFG_W-1:0]     prio_q;
  logic                 ov_q;
  logic [RUN_W-1:0]     o_run_q;
  logic [TIME_W-1:0]    o_cnt_q;
  logic [MASK_W-1:0]    o_mask_q;

  logic                 in_acc;
  logic                 rd_en;
  logic [TID_W-1:0]     rd_addr;
  entry_t               rd_data;
  entry_t               nxt;
  tbl_wr_t              wr;
  pick_upd_t            upd;
  logic [IDX_W-1:0]     sel;
  logic [THREADS-1:0]   rdy;
  logic [VEC_W-1:0]     rdy_ext;
  logic                 delay_nz;
  logic                 do_tick;
  logic                 do_pick;
  logic [IDX_W-1:0]     new_run;
  logic [MASK_W-1:0]    new_mask;
  logic                 out_free;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !ov_q || out_o.ready;

  assign delay_nz = (delay_q != '0);
  assign do_tick  = (act_q == ACT_TICK) || (act_q == ACT_SUSPEND && delay_nz);
  assign do_pick  = do_tick || (act_q == ACT_START);

  // Table read side of the sweep.
  assign rd_en   = (state_q == S_SWEEP) && (ctr_q < CTR_W'(THREADS));
  assign rd_addr = ctr_q[TID_W-1:0];

  pts_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Modify the entry read last cycle according to the action.
  always_comb begin
    nxt = rd_data;
    case (act_q)
      ACT_START: begin
        nxt.status = enabled_of(en_q, pidx_q) ? ST_READY : ST_NONE;
        nxt.wake   = '0;
      end
      ACT_TICK: begin
        if (rd_data.status == ST_SUSP && rd_data.wake == cnt_q) begin
          nxt.status = ST_READY;
          nxt.wake   = '0;
        end
      end
      ACT_SUSPEND: begin
        // A freshly suspended thread cannot wake in the same tick.
        if (delay_nz) begin
          if (IDX_W'(pidx_q) == run_q && rd_data.status == ST_READY) begin
            nxt.status = ST_SUSP;
            nxt.wake   = cnt_q + delay_q;
          end else if (rd_data.status == ST_SUSP && rd_data.wake == cnt_q) begin
            nxt.status = ST_READY;
            nxt.wake   = '0;
          end
        end
      end
      ACT_BLOCK: begin
        if (CMP_W'(idx_q) == CMP_W'(pidx_q) && rd_data.status != ST_NONE) begin
          nxt.status = ST_BLOCK;
        end
      end
      ACT_RESUME: begin
        if (CMP_W'(idx_q) == CMP_W'(pidx_q) &&
            (rd_data.status == ST_BLOCK || rd_data.status == ST_SUSP)) begin
          nxt.status = ST_READY;
        end
      end
      default: begin
        nxt = rd_data;
      end
    endcase
  end

  // Write back and hand the new entry to the picker.
  always_comb begin
    wr.en      = pend_q;
    wr.addr    = pidx_q;
    wr.data    = nxt;
    upd.clear  = in_acc;
    upd.valid  = pend_q;
    upd.idx    = pidx_q;
    upd.ready  = (nxt.status == ST_READY);
    upd.prio   = prio_of(prio_q, pidx_q);
  end

  pts_picker u_picker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .sel_o   (sel),
    .ready_o (rdy)
  );

  // Result of the finished sweep.
  assign new_run = do_pick ? sel : run_q;
  assign rdy_ext = VEC_W'(rdy);
  always_comb begin
    for (int k = 0; k < MASK_W; k++) begin
      new_mask[k] = rdy_ext[k] && (new_run != IDX_W'(k));
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= '0;
      prio_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_THREAD_ENABLE: en_q   <= cfg_wdata_i[MASK_W-1:0];
        REG_PRIORITIES:    prio_q <= cfg_wdata_i;
        default:           en_q   <= en_q;
      endcase
    end
  end

  // Sequencer, scheduler state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ctr_q    <= '0;
      pend_q   <= 1'b0;
      pidx_q   <= '0;
      act_q    <= ACT_START;
      idx_q    <= '0;
      delay_q  <= '0;
      cnt_q    <= '0;
      run_q    <= IDX_W'(THREADS);
      ov_q     <= 1'b0;
      o_run_q  <= '0;
      o_cnt_q  <= '0;
      o_mask_q <= '0;
    end else begin
      // In S_DONE the result register is refilled below instead.
      if (ov_q && out_o.ready && state_q != S_DONE) begin
        ov_q <= 1'b0;
      end
      pend_q <= rd_en;
      pidx_q <= rd_addr;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            act_q   <= action_e'(in_i.action);
            idx_q   <= in_i.thread_index;
            delay_q <= in_i.delay;
            ctr_q   <= '0;
            state_q <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          ctr_q <= ctr_q + CTR_W'(1);
          if (ctr_q == CTR_W'(THREADS)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            run_q    <= new_run;
            if (do_tick) begin
              cnt_q   <= cnt_q + TIME_W'(1);
              o_cnt_q <= cnt_q + TIME_W'(1);
            end else begin
              o_cnt_q <= cnt_q;
            end
            o_run_q  <= RUN_W'(new_run);
            o_mask_q <= new_mask;
            ov_q     <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.running_thread = o_run_q;
  assign out_o.tick_count     = o_cnt_q;
  assign out_o.ready_mask     = o_mask_q;

  // Table writes happen only while sweeping.
  a_wr_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (state_q == S_SWEEP))
    else $error("table written outside a sweep");

  // The read and the write back of one cycle never touch the same entry.
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr.en) |-> (rd_addr != wr.addr))
    else $error("table read and write collide");

  // The running index never points past the idle thread.
  a_run_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= IDX_W'(THREADS))
    else $error("running index out of range");

  // A picked thread other than idle is in the ready set.
  a_pick_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && sel != IDX_W'(THREADS)) |-> rdy[sel[TID_W-1:0]])
    else $error("picked thread is not ready");

  // The tick counter moves only when a sweep completes.
  a_cnt_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> ($past(state_q) == S_DONE))
    else $error("tick counter changed outside completion");

endmodule

[hdl/pts_table.sv]
// Thread table: synchronous memory of status and wake time per thread.
// Depends on pts_pkg. One write and one read port; read data is registered and comes in the cycle after the read.
module pts_table (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pts_pkg::tbl_wr_t        wr_i,
  input  logic                    rd_en_i,
  input  logic [pts_pkg::TID_W-1:0] rd_addr_i,
  output pts_pkg::entry_t         rd_data_o
);
  import pts_pkg::*;

  entry_t               mem_q [THREADS];
  logic [THREADS-1:0]   vld_q;
  entry_t               rd_data_q;
  logic                 rd_vld_q;

  // Storage array, no reset; entries are written before they mean anything.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits make an unwritten entry read as not created with wake time zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

[hdl/pts_picker.sv]
// Picker: walks the updated entries and keeps the best ready thread and ready set.
// Depends on pts_pkg. Entries arrive one per cycle in ascending index order.
module pts_picker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pts_pkg::pick_upd_t        upd_i,
  output logic [pts_pkg::IDX_W-1:0] sel_o,
  output logic [pts_pkg::THREADS-1:0] ready_o
);
  import pts_pkg::*;

  logic [PRIO_W-1:0]   best_q;
  logic [IDX_W-1:0]    sel_q;
  logic [THREADS-1:0]  rdy_q;

  // Strictly greater keeps the lower index on a tie.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      sel_q  <= IDX_W'(THREADS);
      rdy_q  <= '0;
    end else if (upd_i.clear) begin
      best_q <= '0;
      sel_q  <= IDX_W'(THREADS);
      rdy_q  <= '0;
    end else if (upd_i.valid) begin
      rdy_q[upd_i.idx] <= upd_i.ready;
      if (upd_i.ready && upd_i.prio > best_q) begin
        best_q <= upd_i.prio;
        sel_q  <= IDX_W'(upd_i.idx);
      end
    end
  end

  assign sel_o   = sel_q;
  assign ready_o = rdy_q;

endmodule

[tb/sv/priority_thread_scheduler_test.sv]
`timescale 1ns / 1ps
// Self-checking test of the priority thread scheduler: a driver sends request words and a monitor
// checks each result word against an in-bench scheduler prediction.
// Depends on pts_pkg, pts_if and the priority_thread_scheduler top level.
module priority_thread_scheduler_test;
  import pts_pkg::*;

  localparam logic [RUN_W-1:0] IDLE_IDX       = RUN_W'(THREADS);
  localparam logic [ACT_W-1:0] ACT_RSVD_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_LAST  = 3'd7;
  // The drain gap is longer than one request takes and leaves some margin on top.
  localparam int DRAIN_GAP  = THREADS + 8;
  localparam int LONG_HOLD  = 200;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [THR_W-1:0]  tid;
    logic [TIME_W-1:0] delay;
  } sched_req_t;

  typedef struct packed {
    logic [RUN_W-1:0]  running;
    logic [TIME_W-1:0] ticks;
    logic [MASK_W-1:0] ready_set;
  } sched_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_idx;
  logic [CFG_W-1:0]  cfg_wdata;

  pts_in_if  req_if ();
  pts_out_if rsp_if ();

  priority_thread_scheduler u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (req_if),
    .out_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Scheduler state as the bench expects it to be.
  status_e           thr_status [THREADS];
  logic [TIME_W-1:0] thr_wake   [THREADS];
  logic [TIME_W-1:0] tick_ctr;
  logic [RUN_W-1:0]  run_idx;
  logic [MASK_W-1:0] en_cfg;
  logic [CFG_W-1:0]  prio_cfg;

  sched_req_t    queued_actions [$];
  sched_result_t pending_schedules [$];
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   hold_token;
  int unsigned   hold_seen;
  int unsigned   hold_left;
  int            err_count;

  // Picks the ready thread with the highest nonzero priority; ties go to the lower index.
  function automatic void repick();
    logic [PRIO_W-1:0] best;
    best = '0;
    run_idx = IDLE_IDX;
    for (int i = 0; i < THREADS; i++) begin
      if (thr_status[i] == ST_READY && prio_cfg[PRIO_W*i +: PRIO_W] > best) begin
        best = prio_cfg[PRIO_W*i +: PRIO_W];
        run_idx = RUN_W'(i);
      end
    end
  endfunction

  // Releases sleepers due at this count, advances the counter and picks again.
  function automatic void advance_tick();
    for (int i = 0; i < THREADS; i++) begin
      if (thr_status[i] == ST_SUSP && thr_wake[i] == tick_ctr) begin
        thr_status[i] = ST_READY;
        thr_wake[i] = '0;
      end
    end
    tick_ctr = tick_ctr + 1'b1;
    repick();
  endfunction

  // Applies one request to the expected state and returns the word that should come back.
  function automatic sched_result_t next_schedule(input sched_req_t r);
    sched_result_t res;
    case (r.action)
      ACT_START: begin
        for (int i = 0; i < THREADS; i++) begin
          thr_status[i] = en_cfg[i] ? ST_READY : ST_NONE;
          thr_wake[i] = '0;
        end
        repick();
      end
      ACT_TICK: advance_tick();
      ACT_SUSPEND: begin
        if (r.delay != '0) begin
          if (run_idx < IDLE_IDX && thr_status[run_idx] == ST_READY) begin
            thr_status[run_idx] = ST_SUSP;
            thr_wake[run_idx] = tick_ctr + r.delay;
          end
          advance_tick();
        end
      end
      ACT_BLOCK: begin
        if (thr_status[r.tid] != ST_NONE) begin
          thr_status[r.tid] = ST_BLOCK;
        end
      end
      ACT_RESUME: begin
        if (thr_status[r.tid] == ST_BLOCK || thr_status[r.tid] == ST_SUSP) begin
          thr_status[r.tid] = ST_READY;
        end
      end
      default: ;
    endcase
    res.running = run_idx;
    res.ticks = tick_ctr;
    res.ready_set = '0;
    for (int i = 0; i < THREADS && i < MASK_W; i++) begin
      if (thr_status[i] == ST_READY && RUN_W'(i) != run_idx) begin
        res.ready_set[i] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void push_req(input logic [ACT_W-1:0] act, input logic [THR_W-1:0] tid,
                                   input logic [TIME_W-1:0] dly);
    sched_req_t r;
    r.action = act;
    r.tid = tid;
    r.delay = dly;
    queued_actions.push_back(r);
  endfunction

  // Random request: mostly ticks, suspends, blocks and resumes, with a few restarts and
  // reserved codes. Delays are mostly short so that sleepers wake within the run.
  function automatic sched_req_t random_req();
    sched_req_t  r;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 4) begin
      r.action = ACT_START;
    end else if (sel < 34) begin
      r.action = ACT_TICK;
    end else if (sel < 60) begin
      r.action = ACT_SUSPEND;
    end else if (sel < 78) begin
      r.action = ACT_BLOCK;
    end else if (sel < 96) begin
      r.action = ACT_RESUME;
    end else begin
      r.action = ACT_W'($urandom_range(ACT_RSVD_LAST, ACT_RSVD_FIRST));
    end
    r.tid = THR_W'($urandom);
    sel = $urandom_range(9);
    if (sel == 0) begin
      r.delay = '0;
    end else if (sel == 1) begin
      r.delay = $urandom;
    end else begin
      r.delay = TIME_W'($urandom_range(6, 1));
    end
    return r;
  endfunction

  // Waits until no request is queued or in flight and every result word has arrived.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (queued_actions.size() != 0 || req_if.valid || pending_schedules.size() != 0);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Register write; the block must be idle.
  task automatic write_reg(input reg_e idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    if (idx == REG_THREAD_ENABLE) begin
      en_cfg = value[MASK_W-1:0];
    end else begin
      prio_cfg = value;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Known values on every input, expected state at its reset values, then reset release.
  initial begin
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = ACT_START;
    req_if.thread_index = '0;
    req_if.delay = '0;
    rsp_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_THREAD_ENABLE;
    cfg_wdata = '0;
    for (int i = 0; i < THREADS; i++) begin
      thr_status[i] = ST_NONE;
      thr_wake[i] = '0;
    end
    tick_ctr = '0;
    run_idx = IDLE_IDX;
    en_cfg = '0;
    prio_cfg = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_token = 0;
    hold_seen = 0;
    hold_left = 0;
    err_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: offers queued request words and predicts each one as it is accepted.
  always @(posedge clk) begin : driver
    sched_req_t sent;
    sched_req_t nxt;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        sent.action = req_if.action;
        sent.tid = req_if.thread_index;
        sent.delay = req_if.delay;
        pending_schedules.push_back(next_schedule(sent));
      end
      if (!req_if.valid || req_if.ready) begin
        if (queued_actions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = queued_actions.pop_front();
          req_if.valid <= 1'b1;
          req_if.action <= nxt.action;
          req_if.thread_index <= nxt.tid;
          req_if.delay <= nxt.delay;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result word and drives the receiver's ready, including
  // a long hold-off whenever a new one is requested.
  always @(posedge clk) begin : monitor
    sched_result_t want;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_schedules.size() == 0) begin
          $error("result word with nothing expected: running_thread %0d", rsp_if.running_thread);
          err_count++;
        end else begin
          want = pending_schedules.pop_front();
          if (rsp_if.running_thread !== want.running) begin
            $error("running_thread: expected %0d, got %0d", want.running, rsp_if.running_thread);
            err_count++;
          end
          if (rsp_if.tick_count !== want.ticks) begin
            $error("tick_count: expected %0d, got %0d", want.ticks, rsp_if.tick_count);
            err_count++;
          end
          if (rsp_if.ready_mask !== want.ready_set) begin
            $error("ready_mask: expected %b, got %b", want.ready_set, rsp_if.ready_mask);
            err_count++;
          end
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Stimulus: directed sequence, then random phases under different settings and idling.
  initial begin : stimulus
    int unsigned       n_items;
    logic [CFG_W-1:0]  prio_val;
    logic [MASK_W-1:0] en_val;
    sched_req_t        parked [$];
    wait (rst_n);
    @(posedge clk);

    // Registers still at reset: nothing created, so everything stays on the idle thread.
    push_req(ACT_TICK, 3'd0, '0);
    push_req(ACT_BLOCK, 3'd3, '0);
    push_req(ACT_RESUME, 3'd3, '0);
    push_req(ACT_RSVD_LAST, 3'd7, '1);
    wait_drained();

    // Threads 4 and 6 tie at the top priority; threads 0 and 7 have priority zero.
    write_reg(REG_THREAD_ENABLE, CFG_W'(8'hFF));
    write_reg(REG_PRIORITIES, 64'h00_FF_10_FF_20_05_01_00);
    push_req(ACT_START, 3'd0, '0);
    push_req(ACT_SUSPEND, 3'd0, '0);
    push_req(ACT_SUSPEND, 3'd5, 32'd2);
    push_req(ACT_BLOCK, 3'd6, '0);
    push_req(ACT_TICK, 3'd0, '0);
    push_req(ACT_TICK, 3'd0, '0);
    push_req(ACT_RESUME, 3'd6, '0);
    push_req(ACT_TICK, 3'd0, '0);
    // Block every thread with a nonzero priority: the idle thread takes over.
    for (int t = 1; t < 7; t++) begin
      push_req(ACT_BLOCK, THR_W'(t), '0);
    end
    push_req(ACT_TICK, 3'd0, '0);
    push_req(ACT_SUSPEND, 3'd0, 32'd5);
    push_req(ACT_RESUME, 3'd2, '0);
    push_req(ACT_TICK, 3'd0, '0);
    // A delay of all ones wraps the wake time to one below the counter.
    push_req(ACT_SUSPEND, 3'd7, 32'hFFFF_FFFF);
    push_req(ACT_RESUME, 3'd2, '0);
    push_req(ACT_RSVD_FIRST, 3'd1, 32'h8000_0001);
    push_req(ACT_START, 3'd4, '0);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      prio_val = {$urandom, $urandom};
      en_val = MASK_W'($urandom);
      case (ph)
        0: begin en_val = '1; n_items = 100; end
        1: begin prio_val = '1; n_items = 90; end
        2: begin en_val = '0; n_items = 30; end
        3: begin prio_val = '0; n_items = 30; end
        4: begin en_val = '1; n_items = 120; end
        default: begin
          // Small priorities make ties common.
          for (int b = 0; b < 8; b++) begin
            prio_val[PRIO_W*b +: PRIO_W] = PRIO_W'($urandom_range(3));
          end
          n_items = 120;
        end
      endcase
      case (ph)
        0, 4: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 64; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 64; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      write_reg(REG_THREAD_ENABLE, CFG_W'(en_val));
      write_reg(REG_PRIORITIES, prio_val);
      push_req(ACT_START, THR_W'($urandom), $urandom);
      for (int k = 0; k < n_items; k++) begin
        queued_actions.push_back(random_req());
      end
      // Receiver holds off while the sender keeps offering, so the block backs up.
      if (ph == 0) begin
        hold_token++;
      end
      // Midway the sender pauses until every result word is back.
      if (ph == 4) begin
        wait (queued_actions.size() < n_items / 2);
        parked = queued_actions;
        queued_actions.delete();
        wait_drained();
        queued_actions = parked;
      end
      wait_drained();
    end

    if (err_count == 0 && pending_schedules.size() == 0) begin
      $display("priority_thread_scheduler_test: done, clean");
    end else begin
      $display("priority_thread_scheduler_test: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("priority_thread_scheduler_test: done, errors");
    $finish;
  end

endmodule
